// File: rtl/core/ofspa_pkg.sv
// Shared types and constants for the oldest free slot pool allocator.
// Used by the slot cell, the cell chain and the top level; no dependencies.
package ofspa_pkg;

  localparam int SlotIdxW = 8;
  localparam int AgeW     = 32;

  localparam logic [5:0] MinActive = 6'd16;
  localparam logic [5:0] MaxActive = 6'd50;

  localparam logic [0:0] ReqAlloc   = 1'b0;
  localparam logic [0:0] ReqRelease = 1'b1;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StBadIdx = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmScan,
    FsmHold
  } state_e;

  typedef struct packed {
    logic                valid;
    logic                found;
    logic [AgeW-1:0]     age;
    logic [SlotIdxW-1:0] idx;
  } token_t;

  typedef struct packed {
    logic                wr_en;
    logic [SlotIdxW-1:0] wr_idx;
    logic [AgeW-1:0]     wr_age;
    logic                clr_en;
    logic [SlotIdxW-1:0] clr_idx;
  } cmd_t;

  typedef struct packed {
    logic [AgeW-1:0] stamp;
    status_e         status;
    logic [5:0]      granted;
  } result_t;

endpackage

// File: rtl/core/ofspa_cell.sv
// One pool slot: used flag, age stamp and one stage of the search token path.
// Depends on ofspa_pkg.
module ofspa_cell #(
  parameter int CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        n_i,
  input  ofspa_pkg::cmd_t   cmd_i,
  input  ofspa_pkg::token_t tok_i,
  output ofspa_pkg::token_t tok_o
);
  import ofspa_pkg::*;

  localparam logic [SlotIdxW-1:0] MyIdx = SlotIdxW'(CellIdx);

  logic            used_q, used_d;
  logic [AgeW-1:0] age_q, age_d;
  token_t          tok_q, tok_d;
  logic            in_pool;
  logic            take;

  assign in_pool = (CellIdx < 64) && (6'(CellIdx) < n_i);
  assign take    = tok_i.valid && in_pool && !used_q &&
                   (!tok_i.found || (age_q < tok_i.age));

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.age   = age_q;
      tok_d.idx   = MyIdx;
    end
  end

  always_comb begin
    used_d = used_q;
    age_d  = age_q;
    if (cmd_i.wr_en && (cmd_i.wr_idx == MyIdx)) begin
      used_d = 1'b1;
      age_d  = cmd_i.wr_age;
    end else if (cmd_i.clr_en && (cmd_i.clr_idx == MyIdx)) begin
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      age_q  <= '0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      age_q  <= age_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/ofspa_chain.sv
// Row of slot cells; the search token moves one cell per cycle.
// Depends on ofspa_pkg and ofspa_cell.
module ofspa_chain #(
  parameter int PoolDepth = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        n_i,
  input  ofspa_pkg::cmd_t   cmd_i,
  input  ofspa_pkg::token_t tok_i,
  output ofspa_pkg::token_t tok_o
);
  import ofspa_pkg::*;

  token_t tok_link [PoolDepth+1];

  assign tok_link[0] = tok_i;

  for (genvar g = 0; g < PoolDepth; g++) begin : g_cell
    ofspa_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .n_i   (n_i),
      .cmd_i (cmd_i),
      .tok_i (tok_link[g]),
      .tok_o (tok_link[g+1])
    );
  end

  assign tok_o = tok_link[PoolDepth];

endmodule

// File: rtl/core/oldest_free_slot_pool_allocator.sv
// Top level of the oldest free slot pool allocator: request control, register port, result word.
// Depends on ofspa_pkg and ofspa_chain.
//
//   channel  | dir | contents
//   s_axis   | in  | tdata: slot_index; tuser: req_type
//   m_axis   | out | tdata: granted_slot, status, stamp
//   apb      | in  | active_count at byte address 0
//
// An allocate sends the search token along the cell row, which it walks one slot a cycle. One
// request is in work at a time; the result register lets the next request start while a result
// waits. Reset clears all used flags, stamps and the counter, and sets active_count to 16. A
// stalled output holds the request path once a second result is ready.
module oldest_free_slot_pool_allocator #(
  parameter int POOL_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [5:0] slot_index, [7:6] zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [5:0] granted_slot, [7:6] status, [39:8] stamp
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ofspa_pkg::*;

  localparam logic [5:0] DepthCap = (POOL_DEPTH > 50) ? MaxActive : 6'(POOL_DEPTH);

  state_e          state_q, state_d;
  logic [5:0]      active_q, active_d;
  logic [5:0]      n;
  logic [AgeW-1:0] cnt_q, cnt_d;
  result_t         res_q, res_d;
  result_t         out_q;
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic            in_fire;
  logic            cfg_wr;
  logic [5:0]      wr_val;
  cmd_t            cmd;
  token_t          tok_in, tok_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
  assign wr_val  = pwdata[5:0];
  assign prdata  = paddr[2] ? 32'd0 : {26'd0, active_q};
  assign n       = (active_q > DepthCap) ? DepthCap : active_q;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    active_d = active_q;
    if (cfg_wr) begin
      if (wr_val < MinActive) begin
        active_d = MinActive;
      end else if (wr_val > MaxActive) begin
        active_d = MaxActive;
      end else begin
        active_d = wr_val;
      end
    end
  end

  ofspa_chain #(
    .PoolDepth(POOL_DEPTH)
  ) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .n_i   (n),
    .cmd_i (cmd),
    .tok_i (tok_in),
    .tok_o (tok_out)
  );

  assign out_load = (state_q == FsmHold) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmIdle: begin
        if (in_fire) begin
          state_d = (s_axis_tuser_i == ReqAlloc) ? FsmScan : FsmHold;
        end
      end
      FsmScan: begin
        if (tok_out.valid) begin
          state_d = FsmHold;
        end
      end
      FsmHold: begin
        if (out_load) begin
          state_d = FsmIdle;
        end
      end
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == FsmIdle);
    tok_in          = '0;
    cmd             = '0;
    res_d           = res_q;
    cnt_d           = cnt_q;
    case (state_q)
      FsmIdle: begin
        if (in_fire) begin
          if (s_axis_tuser_i == ReqAlloc) begin
            tok_in.valid = 1'b1;
          end else begin
            res_d.granted = s_axis_tdata_i[5:0];
            res_d.stamp   = '0;
            if (s_axis_tdata_i[5:0] < n) begin
              res_d.status = StOk;
              cmd.clr_en   = 1'b1;
              cmd.clr_idx  = {{(SlotIdxW-6){1'b0}}, s_axis_tdata_i[5:0]};
            end else begin
              res_d.status = StBadIdx;
            end
          end
        end
      end
      FsmScan: begin
        if (tok_out.valid) begin
          if (tok_out.found) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_idx    = tok_out.idx;
            cmd.wr_age    = cnt_q;
            res_d.granted = tok_out.idx[5:0];
            res_d.status  = StOk;
            res_d.stamp   = cnt_q;
            cnt_d         = cnt_q + 32'd1;
          end else begin
            res_d.granted = '0;
            res_d.status  = StFull;
            res_d.stamp   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmIdle;
      active_q    <= MinActive;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |=> (cnt_q == $past(cnt_q) + 32'd1))
    else $error("age counter did not advance after a grant");

  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_out.valid |-> (state_q == FsmScan))
    else $error("search token left the row outside a scan");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:6] != 2'd3))
    else $error("result word carries an undefined status");
`endif

endmodule
